/* rtl/dtq_pkg.sv */
// Package for the deadline timer queue.
// Holds field widths, the fire limit and the sequencer types; no dependencies.
package dtq_pkg;

    localparam int MAX_FIRE = 16;
    localparam int FIRE_IW  = $clog2(MAX_FIRE);
    localparam int FIRE_CW  = $clog2(MAX_FIRE + 1);
    localparam int TIME_W   = 48;
    localparam int DELAY_W  = 31;
    localparam int TASK_W   = 8;
    localparam int MIN_W    = 20;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_DRAIN = 9'b000000100,
        S_WRITE = 9'b000001000,
        S_FIRED = 9'b000010000,
        S_REIN  = 9'b000100000,
        S_FIN   = 9'b001000000,
        S_CLAMP = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        K_INS  = 2'd0,
        K_FIRE = 2'd1,
        K_MIN  = 2'd2
    } t_kind;

endpackage

/* rtl/deadline_timer_queue.sv */
// Deadline timer queue top level: timer table, scan sequencer and result port.
// Depends on dtq_pkg and dtq_ram.
//
// The block keeps up to TIMER_SLOTS timers in a RAM and drives one alarm. Every
// operation is carried out by scans that read the timer RAM one slot a cycle
// through a single compare unit, each scan covering all TIMER_SLOTS slots. An
// add takes one scan before its single result word. An expire takes one scan
// per fired timer, plus one that finds none if fewer than MAX_FIRE fire, one
// scan per repeating timer it reloads, and a final scan for the earliest
// deadline, followed by one result word per fired timer, or a single word if
// none fired. The input is not ready until the last result word is taken.
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], now_us[49:2], delay_us[80:50], task_id[88:81]
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fired_task[7:0], alarm_set[8], alarm_delay_us[56:9], queue_empty[57], dropped[58]
    output logic [63:0] m_axis_tdata,
    // fired_valid[0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_cfg_data
);

    localparam int IW = $clog2(TIMER_SLOTS);
    localparam int EW = TIME_W + DELAY_W + TASK_W;
    localparam logic [IW-1:0] LAST_SLOT = IW'(TIMER_SLOTS - 1);

    t_state r_state;
    t_kind  r_kind;

    logic [MIN_W-1:0]   r_min;
    logic [TIMER_SLOTS-1:0] r_valid;

    logic               r_expire;
    logic [TIME_W-1:0]  r_now;
    logic [DELAY_W-1:0] r_delay;
    logic [TIME_W-1:0]  r_key;
    logic [DELAY_W-1:0] r_kper;
    logic [TASK_W-1:0]  r_ktask;

    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_pidx;
    logic               r_pv;

    logic               r_found;
    logic [IW-1:0]      r_bidx;
    logic [TIME_W-1:0]  r_bdl;
    logic [DELAY_W-1:0] r_bper;
    logic [TASK_W-1:0]  r_btask;
    logic               r_mf;
    logic [IW-1:0]      r_midx;
    logic               r_ff;
    logic [IW-1:0]      r_fidx;

    logic [DELAY_W-1:0] r_lper  [MAX_FIRE];
    logic [TASK_W-1:0]  r_ltask [MAX_FIRE];
    logic [FIRE_CW-1:0] r_nfired;
    logic [FIRE_CW-1:0] r_rk;
    logic [FIRE_IW-1:0] r_oc;

    logic               r_ev;
    logic [TIME_W-1:0]  r_edl;
    logic               r_aset;
    logic [TIME_W-1:0]  r_diff;
    logic [TIME_W-1:0]  r_adelay;
    logic               r_drop;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [EW-1:0]      ram_rdata;

    logic [TIME_W-1:0]  rd_dl;
    logic [DELAY_W-1:0] rd_per;
    logic [TASK_W-1:0]  rd_task;
    logic               rd_v;
    logic               best_hit;

    logic [TIME_W:0]    in_sum;
    logic [TIME_W:0]    re_sum;
    logic [DELAY_W-1:0] re_per;
    logic [TIME_W-1:0]  min_eff;
    logic [FIRE_CW-1:0] out_n;
    logic               out_last;
    logic               in_acc;
    logic               out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    assign rd_dl   = ram_rdata[EW-1 -: TIME_W];
    assign rd_per  = ram_rdata[TASK_W +: DELAY_W];
    assign rd_task = ram_rdata[TASK_W-1:0];
    assign rd_v    = r_valid[r_pidx];
    assign best_hit = rd_v && (r_kind == K_MIN || rd_dl < r_now) && (!r_found || rd_dl < r_bdl);

    assign in_sum = {1'b0, s_axis_tdata[49:2]} + {{(TIME_W + 1 - DELAY_W){1'b0}}, s_axis_tdata[80:50]};
    assign re_per = r_lper[r_rk[FIRE_IW-1:0]];
    assign re_sum = {1'b0, r_now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, re_per};
    assign min_eff = (r_min == '0) ? TIME_W'(1) : {{(TIME_W - MIN_W){1'b0}}, r_min};

    assign ram_we    = (r_state == S_WRITE) && (r_mf || r_ff);
    assign ram_waddr = r_mf ? r_midx : r_fidx;

    dtq_ram #(
        .WIDTH (EW),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_key, r_kper, r_ktask}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_INS;
            r_min    <= MIN_W'(100);
            r_valid  <= '0;
            r_ev     <= 1'b0;
            r_edl    <= '0;
            r_pv     <= 1'b0;
            r_nfired <= '0;
            r_rk     <= '0;
            r_oc     <= '0;
            r_found  <= 1'b0;
            r_mf     <= 1'b0;
            r_ff     <= 1'b0;
            r_aset   <= 1'b0;
            r_drop   <= 1'b0;
            r_expire <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_min <= i_cfg_data;
            end

            r_pv   <= (r_state == S_SCAN);
            r_pidx <= r_idx;
            if (r_pv) begin
                if (r_kind == K_INS) begin
                    if (rd_v && rd_dl == r_key) begin
                        r_mf   <= 1'b1;
                        r_midx <= r_pidx;
                    end
                    if (!rd_v && !r_ff) begin
                        r_ff   <= 1'b1;
                        r_fidx <= r_pidx;
                    end
                end else if (best_hit) begin
                    r_found <= 1'b1;
                    r_bidx  <= r_pidx;
                    r_bdl   <= rd_dl;
                    r_bper  <= rd_per;
                    r_btask <= rd_task;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_now    <= s_axis_tdata[49:2];
                        r_delay  <= s_axis_tdata[80:50];
                        r_expire <= s_axis_tdata[1];
                        r_key    <= in_sum[TIME_W] ? '1 : in_sum[TIME_W-1:0];
                        r_kper   <= s_axis_tdata[0] ? s_axis_tdata[80:50] : '0;
                        r_ktask  <= s_axis_tdata[88:81];
                        r_kind   <= s_axis_tdata[1] ? K_FIRE : K_INS;
                        r_nfired <= '0;
                        r_drop   <= 1'b0;
                        r_found  <= 1'b0;
                        r_mf     <= 1'b0;
                        r_ff     <= 1'b0;
                        r_idx    <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == LAST_SLOT) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_idx <= '0;
                    case (r_kind)
                        K_INS:   r_state <= S_WRITE;
                        K_FIRE:  r_state <= S_FIRED;
                        default: r_state <= S_FIN;
                    endcase
                end
                S_WRITE: begin
                    if (!r_mf && r_ff) begin
                        r_valid[r_fidx] <= 1'b1;
                    end
                    if (r_expire) begin
                        r_state <= S_REIN;
                    end else begin
                        r_drop <= !r_mf && !r_ff;
                        if ((r_mf || r_ff) && (!r_ev || r_key < r_edl)) begin
                            r_ev   <= 1'b1;
                            r_edl  <= r_key;
                            r_aset <= 1'b1;
                        end else begin
                            r_aset <= 1'b0;
                        end
                        r_diff  <= {{(TIME_W - DELAY_W){1'b0}}, r_delay};
                        r_state <= S_CLAMP;
                    end
                end
                S_FIRED: begin
                    if (r_found) begin
                        r_valid[r_bidx] <= 1'b0;
                        r_lper[r_nfired[FIRE_IW-1:0]]  <= r_bper;
                        r_ltask[r_nfired[FIRE_IW-1:0]] <= r_btask;
                        r_nfired <= r_nfired + 1'b1;
                        r_found  <= 1'b0;
                        if (r_nfired == FIRE_CW'(MAX_FIRE - 1)) begin
                            r_rk    <= '0;
                            r_state <= S_REIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_rk    <= '0;
                        r_state <= S_REIN;
                    end
                end
                S_REIN: begin
                    r_found <= 1'b0;
                    r_mf    <= 1'b0;
                    r_ff    <= 1'b0;
                    r_idx   <= '0;
                    if (r_rk == r_nfired) begin
                        r_kind  <= K_MIN;
                        r_state <= S_SCAN;
                    end else begin
                        r_rk <= r_rk + 1'b1;
                        if (re_per != '0) begin
                            r_key   <= re_sum[TIME_W] ? '1 : re_sum[TIME_W-1:0];
                            r_kper  <= re_per;
                            r_ktask <= r_ltask[r_rk[FIRE_IW-1:0]];
                            r_kind  <= K_INS;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_FIN: begin
                    if (r_valid == '0) begin
                        r_ev   <= 1'b0;
                        r_aset <= 1'b0;
                    end else begin
                        r_ev   <= 1'b1;
                        r_edl  <= r_bdl;
                        r_aset <= 1'b1;
                    end
                    r_diff  <= (r_bdl > r_now) ? r_bdl - r_now : '0;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (!r_aset) begin
                        r_adelay <= '0;
                    end else if (r_diff < min_eff) begin
                        r_adelay <= min_eff;
                    end else begin
                        r_adelay <= r_diff;
                    end
                    r_oc    <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_oc <= r_oc + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign out_n    = (r_nfired == '0) ? FIRE_CW'(1) : r_nfired;
    assign out_last = ({1'b0, r_oc} == FIRE_CW'(out_n - 1'b1));

    assign s_axis_tready   = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign m_axis_tvalid   = (r_state == S_OUT);
    assign m_axis_tlast    = out_last;
    assign m_axis_tuser[0] = (r_nfired != '0);
    assign m_axis_tdata    = {5'd0, r_drop, (r_valid == '0), r_adelay, r_aset,
                              (r_nfired != '0) ? r_ltask[r_oc] : {TASK_W{1'b0}}};

endmodule

/* rtl/dtq_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/deadline_timer_queue_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for deadline_timer_queue: a model of the timer table
// predicts every result word, which is checked against the master stream.
// Depends on dtq_pkg and the deadline_timer_queue RTL.
module deadline_timer_queue_test
    import dtq_pkg::*;
();

    localparam int SLOTS = 16;
    localparam logic [1:0] OP_ONESHOT = 2'd0;
    localparam logic [1:0] OP_REPEAT  = 2'd1;
    localparam logic [1:0] OP_EXPIRE  = 2'd2;
    localparam logic [1:0] OP_EXPIRE3 = 2'd3;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic        fired_valid;
        logic [7:0]  fired_task;
        logic        last;
        logic        alarm_set;
        logic [47:0] alarm_delay;
        logic        queue_empty;
        logic        dropped;
    } t_timer_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [19:0] i_cfg_data;

    deadline_timer_queue #(.TIMER_SLOTS(SLOTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Mirror of the timer table.
    logic              slot_used [SLOTS];
    logic [47:0]       slot_deadline [SLOTS];
    logic [30:0]       slot_period [SLOTS];
    logic [7:0]        slot_task [SLOTS];
    logic              soonest_valid;
    logic [47:0]       soonest_deadline;
    logic [19:0]       min_alarm;
    t_timer_word       pending_words [$];
    int                errors;
    int                cycles;
    bit                no_idle;
    logic [47:0]       clock_now;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0) return 0;
        return int'($urandom_range(0, 18));
    endfunction

    function automatic logic [47:0] clamp_alarm(input logic [47:0] d);
        logic [47:0] m;
        m = (min_alarm == 0) ? 48'd1 : {28'd0, min_alarm};
        return (d < m) ? m : d;
    endfunction

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [30:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {18'd0, b};
        return s[48] ? TIME_MAX : s[47:0];
    endfunction

    // Returns 1 when the table is full and the timer is lost.
    function automatic bit store_timer(input logic [47:0] dl, input logic [30:0] per,
                                       input logic [7:0] tid);
        int free_slot;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_deadline[i] == dl) begin
                slot_period[i] = per;
                slot_task[i] = tid;
                return 1'b0;
            end
            if (!slot_used[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) return 1'b1;
        slot_used[free_slot] = 1'b1;
        slot_deadline[free_slot] = dl;
        slot_period[free_slot] = per;
        slot_task[free_slot] = tid;
        return 1'b0;
    endfunction

    function automatic bit table_idle();
        for (int i = 0; i < SLOTS; i++) if (slot_used[i]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic predict_timer_words(input logic [1:0] op, input logic [47:0] now,
                                       input logic [30:0] dly, input logic [7:0] tid);
        t_timer_word w;
        logic [7:0]  fired_tid [16];
        logic [30:0] fired_per [16];
        int          nfired, best, n;
        bit          drop, empty;
        logic [47:0] dl;
        w = '0;
        nfired = 0;
        if (!op[1]) begin
            dl = sat_add(now, dly);
            drop = store_timer(dl, (op == OP_REPEAT) ? dly : 31'd0, tid);
            if (!drop && (!soonest_valid || dl < soonest_deadline)) begin
                soonest_valid = 1'b1;
                soonest_deadline = dl;
                w.alarm_set = 1'b1;
                w.alarm_delay = clamp_alarm({17'd0, dly});
            end
            w.last = 1'b1;
            w.queue_empty = table_idle();
            w.dropped = drop;
            pending_words.push_back(w);
        end else begin
            while (nfired < MAX_FIRE) begin
                best = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i] && slot_deadline[i] < now &&
                        (best < 0 || slot_deadline[i] < slot_deadline[best])) best = i;
                if (best < 0) break;
                fired_tid[nfired] = slot_task[best];
                fired_per[nfired] = slot_period[best];
                slot_used[best] = 1'b0;
                nfired++;
            end
            for (int k = 0; k < nfired; k++)
                if (fired_per[k] != 0)
                    void'(store_timer(sat_add(now, fired_per[k]), fired_per[k], fired_tid[k]));
            empty = table_idle();
            if (empty) begin
                soonest_valid = 1'b0;
            end else begin
                best = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i] && (best < 0 || slot_deadline[i] < slot_deadline[best]))
                        best = i;
                soonest_valid = 1'b1;
                soonest_deadline = slot_deadline[best];
                w.alarm_set = 1'b1;
                w.alarm_delay = clamp_alarm(soonest_deadline > now ?
                                            soonest_deadline - now : 48'd0);
            end
            w.queue_empty = empty;
            n = (nfired > 0) ? nfired : 1;
            for (int k = 0; k < n; k++) begin
                w.fired_valid = (nfired > 0);
                w.fired_task = (nfired > 0) ? fired_tid[k] : 8'd0;
                w.last = (k == n - 1);
                pending_words.push_back(w);
            end
        end
    endtask

    task automatic send_timer_op(input logic [1:0] op, input logic [47:0] now,
                                 input logic [30:0] dly, input logic [7:0] tid);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, tid, dly, now, op};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_timer_words(op, now, dly, tid);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_min_alarm(input logic [19:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        min_alarm = value;
    endtask

    function automatic void report(input string field, input logic [47:0] exp_v,
                                   input logic [47:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        end
    endfunction

    // Result checker: every word taken is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_timer_word e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %0h", $time, m_axis_tdata);
            end else begin
                e = pending_words.pop_front();
                report("fired_valid", e.fired_valid, m_axis_tuser[0]);
                report("fired_task", e.fired_task, m_axis_tdata[7:0]);
                report("last", e.last, m_axis_tlast);
                report("alarm_set", e.alarm_set, m_axis_tdata[8]);
                report("alarm_delay_us", e.alarm_delay, m_axis_tdata[56:9]);
                report("queue_empty", e.queue_empty, m_axis_tdata[57]);
                report("dropped", e.dropped, m_axis_tdata[58]);
            end
        end
    end

    // Sink with random back-pressure.
    initial begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = draw_gap();
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic test_add_extremes();
        send_timer_op(OP_ONESHOT, 48'd0, 31'd0, 8'h00);
        send_timer_op(OP_ONESHOT, 48'd1000, 31'h7FFF_FFFF, 8'hFF);
        send_timer_op(OP_REPEAT, 48'd1000, 31'd0, 8'h5A);
        send_timer_op(OP_EXPIRE, 48'd2000, 31'd0, 8'h00);
        send_timer_op(OP_REPEAT, TIME_MAX, 31'h7FFF_FFFF, 8'hA5);
        send_timer_op(OP_EXPIRE3, TIME_MAX, 31'h7FFF_FFFF, 8'hFF);
    endtask

    task automatic test_full_table_and_overwrite();
        for (int i = 0; i < 17; i++)
            send_timer_op(i[0] ? OP_REPEAT : OP_ONESHOT, 48'd5000, 31'(17 - i), 8'(i));
        send_timer_op(OP_ONESHOT, 48'd5000, 31'd3, 8'hEE);
        send_timer_op(OP_EXPIRE, TIME_MAX, 31'd0, 8'd0);
        send_timer_op(OP_EXPIRE, TIME_MAX, 31'd0, 8'd0);
    endtask

    task automatic test_min_alarm_extremes();
        write_min_alarm(20'd0);
        send_timer_op(OP_ONESHOT, 48'd10, 31'd0, 8'h11);
        write_min_alarm(20'hFFFFF);
        send_timer_op(OP_ONESHOT, 48'd10, 31'd5, 8'h22);
        send_timer_op(OP_EXPIRE, TIME_MAX, 31'd0, 8'd0);
        write_min_alarm(20'd1);
    endtask

    task automatic test_random_traffic(input int items);
        logic [1:0]  op;
        logic [30:0] dly;
        logic [47:0] now;
        int          pick;
        for (int i = 0; i < items; i++) begin
            pick = int'($urandom_range(0, 99));
            now = clock_now;
            if (pick < 45) begin
                op = $urandom_range(0, 1) ? OP_REPEAT : OP_ONESHOT;
                dly = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 3000));
            end else if (pick < 90) begin
                op = $urandom_range(0, 4) == 0 ? OP_EXPIRE3 : OP_EXPIRE;
                clock_now = clock_now + 48'($urandom_range(0, 2500));
                now = clock_now;
                dly = 31'($urandom);
            end else begin
                op = 2'($urandom);
                now = {16'($urandom), 32'($urandom)};
                dly = 31'($urandom);
            end
            send_timer_op(op, now, dly, 8'($urandom));
        end
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        clock_now = 48'd100;
        min_alarm = 20'd100;
        soonest_valid = 1'b0;
        soonest_deadline = '0;
        for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_add_extremes();
        test_full_table_and_overwrite();
        test_min_alarm_extremes();
        test_random_traffic(90);
        write_min_alarm(20'($urandom_range(1, 1000000)));
        no_idle = 1'b1;
        test_random_traffic(50);
        no_idle = 1'b0;
        write_min_alarm(20'($urandom_range(1, 3000)));
        test_random_traffic(100);
        settle();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* deadline_timer_queue.f */
rtl/dtq_pkg.sv
rtl/dtq_ram.sv
rtl/deadline_timer_queue.sv
tb/deadline_timer_queue_test.sv
